// ===== sv/sbpg_pkg.sv =====
package sbpg_pkg;

  // bag geometry
  localparam int BAG_SIZE  = 7;
  localparam int PIECE_W   = 3;
  localparam int IDX_W     = $clog2(BAG_SIZE);
  localparam int LEFT_W    = $clog2(BAG_SIZE + 1);

  // generator and remainder unit
  localparam int GEN_W     = 32;
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = GEN_W / MOD_BITS;
  localparam int MSTEP_W   = $clog2(MOD_STEPS);
  localparam logic [GEN_W-1:0] SEED_RESET = 32'h1234_5678;

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SEED = '0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_XS,
    ST_MOD,
    ST_RDJ,
    ST_WRI,
    ST_WRJ,
    ST_RDP,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start_fill;
    logic start_serve;
    logic fill_wr;
    logic gen_step;
    logic mod_run;
    logic rdb_load;
    logic wr_i;
    logic wr_j;
    logic rda_pos;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bag_empty;
    logic fill_last;
    logic mod_last;
    logic i_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/shuffled_bag_piece_generator.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------
// in_       | input     | in_valid / in_ready    | in_take
// out_      | output    | out_valid / out_ready  | out_piece, out_refilled
// apb       | input     | psel/penable/pwrite    | paddr, pwdata, prdata
//
// a request with pieces left in the bag: bag memory read, then result
// load into the output register
// a request on an empty bag: a fill of all BAG_SIZE entries, then per swap
// xorshift, remainder reduction a byte at a time, read, two writes through the
// single memory write port
// an idle tick is taken without leaving idle; in_ready is high only while idle
// reset clears generator to the seed reset value and empties the bag
// a stalled result holds in the output register; the next request is
// taken and worked on meanwhile and waits only to load its result
module shuffled_bag_piece_generator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbpg_pkg::PIECE_W-1:0] out_piece,
  output logic                         out_refilled,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbpg_pkg::DATA_W-1:0]  pwdata,
  output logic [sbpg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  sbpg_pkg::cmd_t    cmd;
  sbpg_pkg::status_t sts;

  // sequencer
  sbpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_take  (in_take),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // generator, bag memory and result register
  sbpg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_piece    (out_piece),
    .out_refilled (out_refilled)
  );

endmodule

// ===== sv/sbpg_ctrl.sv =====
module sbpg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_take,
  output logic              in_ready,
  input  sbpg_pkg::status_t sts,
  output sbpg_pkg::cmd_t    cmd
);

  sbpg_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbpg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbpg_pkg::ST_IDLE: begin
        if (in_valid && in_take) begin
          state_nxt = sts.bag_empty ? sbpg_pkg::ST_FILL : sbpg_pkg::ST_RDP;
        end
      end
      sbpg_pkg::ST_FILL: begin
        if (sts.fill_last) begin
          state_nxt = sbpg_pkg::ST_XS;
        end
      end
      sbpg_pkg::ST_XS:  state_nxt = sbpg_pkg::ST_MOD;
      sbpg_pkg::ST_MOD: begin
        if (sts.mod_last) begin
          state_nxt = sbpg_pkg::ST_RDJ;
        end
      end
      sbpg_pkg::ST_RDJ: state_nxt = sbpg_pkg::ST_WRI;
      sbpg_pkg::ST_WRI: state_nxt = sbpg_pkg::ST_WRJ;
      sbpg_pkg::ST_WRJ: begin
        state_nxt = sts.i_last ? sbpg_pkg::ST_RDP : sbpg_pkg::ST_XS;
      end
      sbpg_pkg::ST_RDP: state_nxt = sbpg_pkg::ST_OUT;
      sbpg_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = sbpg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbpg_pkg::ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      sbpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_take) begin
          cmd.start_fill  = sts.bag_empty;
          cmd.start_serve = !sts.bag_empty;
        end
      end
      sbpg_pkg::ST_FILL: cmd.fill_wr  = 1'b1;
      sbpg_pkg::ST_XS:   cmd.gen_step = 1'b1;
      sbpg_pkg::ST_MOD:  cmd.mod_run  = 1'b1;
      sbpg_pkg::ST_RDJ:  cmd.rdb_load = 1'b1;
      sbpg_pkg::ST_WRI:  cmd.wr_i     = 1'b1;
      sbpg_pkg::ST_WRJ:  cmd.wr_j     = 1'b1;
      sbpg_pkg::ST_RDP:  cmd.rda_pos  = 1'b1;
      sbpg_pkg::ST_OUT:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/sbpg_dp.sv =====
module sbpg_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sbpg_pkg::cmd_t               cmd,
  output sbpg_pkg::status_t            sts,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbpg_pkg::DATA_W-1:0]  pwdata,
  output logic [sbpg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbpg_pkg::PIECE_W-1:0] out_piece,
  output logic                         out_refilled
);

  localparam logic [sbpg_pkg::IDX_W-1:0]  IDX_LAST  = sbpg_pkg::IDX_W'(sbpg_pkg::BAG_SIZE - 1);
  localparam logic [sbpg_pkg::IDX_W-1:0]  IDX_ONE   = sbpg_pkg::IDX_W'(1);
  localparam logic [sbpg_pkg::LEFT_W-1:0] LEFT_FULL = sbpg_pkg::LEFT_W'(sbpg_pkg::BAG_SIZE);
  localparam logic [sbpg_pkg::MSTEP_W-1:0] MSTEP_LAST =
    sbpg_pkg::MSTEP_W'(sbpg_pkg::MOD_STEPS - 1);

  // one xorshift step
  function automatic logic [sbpg_pkg::GEN_W-1:0] xorshift(input logic [sbpg_pkg::GEN_W-1:0] x);
    logic [sbpg_pkg::GEN_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  logic [sbpg_pkg::PIECE_W-1:0] bag_mem [sbpg_pkg::BAG_SIZE];

  logic [sbpg_pkg::GEN_W-1:0]   seed_r, gen_r, gen_nxt;
  logic [sbpg_pkg::GEN_W-1:0]   div_r;
  logic [sbpg_pkg::IDX_W-1:0]   idx_r;
  logic [sbpg_pkg::IDX_W-1:0]   rem_r, rem_nxt;
  logic [sbpg_pkg::MSTEP_W-1:0] mstep_r;
  logic [sbpg_pkg::LEFT_W-1:0]  left_r;
  logic [sbpg_pkg::PIECE_W-1:0] rda_r, rdb_r;
  logic                         refill_r;
  logic                         out_valid_r;
  logic [sbpg_pkg::PIECE_W-1:0] out_piece_r;
  logic                         out_refilled_r;

  logic [sbpg_pkg::IDX_W:0]     modulus;
  logic [sbpg_pkg::IDX_W-1:0]   pos;
  logic [sbpg_pkg::LEFT_W-1:0]  pos_full;
  logic [sbpg_pkg::IDX_W-1:0]   rda_addr;
  logic                         wr_en;
  logic [sbpg_pkg::IDX_W-1:0]   wr_addr;
  logic [sbpg_pkg::PIECE_W-1:0] wr_data;
  logic                         seed_wr;
  logic [sbpg_pkg::REG_IDX_W-1:0] reg_idx;

  // register access
  assign reg_idx = paddr[sbpg_pkg::ADDR_W-1:2];
  assign seed_wr = psel && penable && pwrite && (reg_idx == sbpg_pkg::REG_SEED);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == sbpg_pkg::REG_SEED) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= sbpg_pkg::SEED_RESET;
    end else if (seed_wr) begin
      seed_r <= pwdata;
    end
  end

  // generator state, reloaded by a seed write
  assign gen_nxt = xorshift(gen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= sbpg_pkg::SEED_RESET;
    end else if (seed_wr) begin
      gen_r <= pwdata;
    end else if (cmd.gen_step) begin
      gen_r <= gen_nxt;
    end
  end

  // remainder unit: restoring reduction, a byte of the value per cycle
  assign modulus = {1'b0, idx_r} + {{sbpg_pkg::IDX_W{1'b0}}, 1'b1};

  always_comb begin
    logic [sbpg_pkg::IDX_W:0] r;
    r = {1'b0, rem_r};
    for (int k = 0; k < sbpg_pkg::MOD_BITS; k++) begin
      r = {r[sbpg_pkg::IDX_W-1:0], div_r[sbpg_pkg::GEN_W-1-k]};
      if (r >= modulus) begin
        r = r - modulus;
      end
    end
    rem_nxt = r[sbpg_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_step) begin
      div_r   <= gen_nxt;
      rem_r   <= '0;
      mstep_r <= '0;
    end else if (cmd.mod_run) begin
      div_r   <= div_r << sbpg_pkg::MOD_BITS;
      rem_r   <= rem_nxt;
      mstep_r <= mstep_r + sbpg_pkg::MSTEP_W'(1);
    end
  end

  // entry index: fill sweep, then shuffle position counting down
  always_ff @(posedge clk) begin
    if (cmd.start_fill) begin
      idx_r <= '0;
    end else if (cmd.fill_wr && (idx_r != IDX_LAST)) begin
      idx_r <= idx_r + IDX_ONE;
    end else if (cmd.wr_j && (idx_r != IDX_ONE)) begin
      idx_r <= idx_r - IDX_ONE;
    end
  end

  // pieces left in the bag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cmd.wr_j && (idx_r == IDX_ONE)) begin
      left_r <= LEFT_FULL;
    end else if (cmd.out_load) begin
      left_r <= left_r - sbpg_pkg::LEFT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_fill) begin
      refill_r <= 1'b1;
    end else if (cmd.start_serve) begin
      refill_r <= 1'b0;
    end
  end

  // bag memory: one write port, two registered read ports
  assign pos_full = LEFT_FULL - left_r;
  assign pos      = pos_full[sbpg_pkg::IDX_W-1:0];
  assign rda_addr = cmd.rda_pos ? pos : idx_r;

  always_comb begin
    wr_en   = cmd.fill_wr || cmd.wr_i || cmd.wr_j;
    wr_addr = idx_r;
    wr_data = sbpg_pkg::PIECE_W'(idx_r);
    if (cmd.wr_i) begin
      wr_data = rdb_r;
    end else if (cmd.wr_j) begin
      wr_addr = rem_r;
      wr_data = rda_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bag_mem[wr_addr] <= wr_data;
    end
    if (cmd.gen_step || cmd.rda_pos) begin
      rda_r <= bag_mem[rda_addr];
    end
    if (cmd.rdb_load) begin
      rdb_r <= bag_mem[rem_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_piece_r    <= rda_r;
      out_refilled_r <= refill_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_piece    = out_piece_r;
  assign out_refilled = out_refilled_r;

  // status
  assign sts.bag_empty = (left_r == '0);
  assign sts.fill_last = (idx_r == IDX_LAST);
  assign sts.mod_last  = (mstep_r == MSTEP_LAST);
  assign sts.i_last    = (idx_r == IDX_ONE);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
